>>> hdl/lru_block_buffer_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit_macros
// Assertion macros for the LRU block buffer cache.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LBC_ASSERT(label, clk_i, rst_i, prop) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error("label");
`define LBC_ASSERT_NR(label, clk_i, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("label");
`else
`define LBC_ASSERT(label, clk_i, rst_i, prop)
`define LBC_ASSERT_NR(label, clk_i, prop)
`endif
`endif

>>> hdl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LRU block buffer cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int unsigned SlotCountDefault = 32;
  localparam logic [31:0] OffsetReset = 32'h0002_0800;
  localparam logic [7:0]  CountMax = 8'hFF;

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_RELEASE = 3'd1,
    OP_PIN     = 3'd2,
    OP_UNPIN   = 3'd3,
    OP_VALID   = 3'd4,
    OP_DIRTY   = 3'd5,
    OP_CLEAN   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_COUNT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT_SCAN,
    S_VIC_SCAN,
    S_RANK,
    S_DONE
  } state_t;

endpackage

>>> hdl/lru_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit
// Buffer cache of SLOT_COUNT slots with LRU recycling.
// ----------------------------------------------------------------------------
// A get walks the slots in recency order one per cycle for a hit, and on a
// miss walks them again from the least recent end for a free victim; the
// single tag compare unit sets that pace. A release that drops a count to
// zero then renumbers the ranks one slot per cycle. Other ops pass from
// S_IDLE straight to S_DONE. The block accepts one item at a time; the
// result waits in an output register, and no new item is taken until it
// has been read.
module lru_block_buffer_cache_unit #(
  parameter int unsigned SLOT_COUNT = lbc_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: op[2:0], dev[10:3], block_number[42:11], slot[47:43]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: slot_out[4:0], hit[5], needs_read[6], disk_block[38:7], status[40:39]
  output logic [47:0] m_tdata
);
  `include "lru_block_buffer_cache_unit_macros.svh"

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  logic [31:0] partition_offset;
  logic [7:0]  tag_device [SLOT_COUNT];
  logic [31:0] tag_block  [SLOT_COUNT];
  logic [7:0]  ref_count  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_mark, dirty_mark;
  logic [IW-1:0] recency_rank [SLOT_COUNT];
  // slot_at[r] is the slot holding rank r (inverse map).
  logic [IW-1:0] slot_at [SLOT_COUNT];

  lbc_pkg::state_t state, state_next;
  lbc_pkg::op_t op;
  logic [7:0]  dev;
  logic [31:0] abs_blk;
  logic [4:0]  slot_in;
  logic [CW-1:0] cnt;
  logic [IW-1:0] cur, target_rank;
  logic [4:0]  res_slot;
  logic res_hit, res_nr;
  logic [31:0] res_disk;
  lbc_pkg::status_t res_status;
  logic out_full;
  logic rel_zero;

  logic tag_match, free;
  logic [IW-1:0] cnt_idx;
  assign cnt_idx = cnt[IW-1:0];
  // Hit scan walks ranks upward; victim scan walks downward.
  assign cur = (state == lbc_pkg::S_HIT_SCAN) ? slot_at[cnt_idx]
             : slot_at[IW'(SLOT_COUNT - 1) - cnt_idx];

  lbc_scan_unit u_scan (
    .dev(dev), .blk(abs_blk), .tag_dev(tag_device[cur]), .tag_blk(tag_block[cur]),
    .count(ref_count[cur]), .dirty(dirty_mark[cur]),
    .tag_match(tag_match), .free(free)
  );

  assign s_tready = (state == lbc_pkg::S_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tdata = {7'd0, res_status, res_disk, res_nr, res_hit, res_slot};

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;
  logic [IW-1:0] sidx;
  assign sidx = IW'(slot_in);
  logic s_ok;
  assign s_ok = 32'(slot_in) < SLOT_COUNT;

  // A release that drops the count to zero goes on to renumber the ranks.
  assign rel_zero = (op == lbc_pkg::OP_RELEASE) && s_ok && (ref_count[sidx] == 8'd1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      lbc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (lbc_pkg::op_t'(s_tdata[2:0]) == lbc_pkg::OP_GET) begin
            state_next = lbc_pkg::S_HIT_SCAN;
          end else begin
            state_next = lbc_pkg::S_DONE;
          end
        end
      end
      lbc_pkg::S_HIT_SCAN: begin
        if (tag_match) state_next = lbc_pkg::S_DONE;
        else if (cnt == CW'(SLOT_COUNT - 1)) state_next = lbc_pkg::S_VIC_SCAN;
      end
      lbc_pkg::S_VIC_SCAN: begin
        if (free || cnt == CW'(SLOT_COUNT - 1)) state_next = lbc_pkg::S_DONE;
      end
      lbc_pkg::S_RANK: if (cnt == CW'(SLOT_COUNT - 1)) state_next = lbc_pkg::S_DONE;
      lbc_pkg::S_DONE: state_next = rel_zero ? lbc_pkg::S_RANK : lbc_pkg::S_IDLE;
      default: state_next = lbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbc_pkg::S_IDLE;
      out_full <= 1'b0;
      partition_offset <= lbc_pkg::OffsetReset;
      valid_mark <= '0;
      dirty_mark <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag_device[i] <= '0;
        tag_block[i] <= '0;
        ref_count[i] <= '0;
        recency_rank[i] <= IW'(SLOT_COUNT - 1 - i);
        slot_at[i] <= IW'(SLOT_COUNT - 1 - i);
      end
    end else begin
      state <= state_next;
      if (cfg_we) partition_offset <= cfg_wdata;
      if (m_tvalid && m_tready) out_full <= 1'b0;
      unique case (state)
        lbc_pkg::S_IDLE: begin
          if (in_acc) begin
            op <= lbc_pkg::op_t'(s_tdata[2:0]);
            dev <= s_tdata[10:3];
            abs_blk <= s_tdata[42:11] + partition_offset;
            slot_in <= s_tdata[47:43];
            cnt <= '0;
            res_hit <= 1'b0;
            res_nr <= 1'b0;
            res_status <= lbc_pkg::ST_OK;
            res_slot <= '0;
            res_disk <= '0;
          end
        end
        lbc_pkg::S_HIT_SCAN: begin
          res_disk <= abs_blk;
          if (tag_match) begin
            res_hit <= 1'b1;
            res_slot <= 5'(cur);
            res_nr <= !valid_mark[cur];
            if (ref_count[cur] == lbc_pkg::CountMax) res_status <= lbc_pkg::ST_COUNT;
            else ref_count[cur] <= ref_count[cur] + 8'd1;
          end
          cnt <= (cnt == CW'(SLOT_COUNT - 1)) ? '0 : cnt + CW'(1);
        end
        lbc_pkg::S_VIC_SCAN: begin
          if (free) begin
            tag_device[cur] <= dev;
            tag_block[cur] <= abs_blk;
            valid_mark[cur] <= 1'b0;
            dirty_mark[cur] <= 1'b0;
            ref_count[cur] <= 8'd1;
            res_slot <= 5'(cur);
            res_nr <= 1'b1;
          end else if (cnt == CW'(SLOT_COUNT - 1)) begin
            res_status <= lbc_pkg::ST_NO_FREE;
          end
          cnt <= cnt + CW'(1);
        end
        lbc_pkg::S_RANK: begin
          // Shift one rank down per cycle, from target down to 1.
          if (cnt_idx < target_rank) begin
            slot_at[target_rank - cnt_idx] <= slot_at[target_rank - cnt_idx - IW'(1)];
            recency_rank[slot_at[target_rank - cnt_idx - IW'(1)]]
              <= target_rank - cnt_idx;
          end
          if (cnt == CW'(SLOT_COUNT - 1)) begin
            slot_at[0] <= sidx;
            recency_rank[sidx] <= '0;
          end
          cnt <= cnt + CW'(1);
        end
        lbc_pkg::S_DONE: begin
          // The result is held back while the ranks are renumbered.
          out_full <= !rel_zero;
          if (op != lbc_pkg::OP_GET) begin
            res_slot <= slot_in;
            if (s_ok) begin
              res_disk <= tag_block[sidx];
              unique case (op)
                lbc_pkg::OP_RELEASE, lbc_pkg::OP_UNPIN: begin
                  if (ref_count[sidx] == '0) res_status <= lbc_pkg::ST_COUNT;
                  else begin
                    ref_count[sidx] <= ref_count[sidx] - 8'd1;
                    if (rel_zero) begin
                      target_rank <= recency_rank[sidx];
                      cnt <= '0;
                      op <= lbc_pkg::OP_NONE;
                    end
                  end
                end
                lbc_pkg::OP_PIN: begin
                  if (ref_count[sidx] == lbc_pkg::CountMax) res_status <= lbc_pkg::ST_COUNT;
                  else ref_count[sidx] <= ref_count[sidx] + 8'd1;
                end
                lbc_pkg::OP_VALID: valid_mark[sidx] <= 1'b1;
                lbc_pkg::OP_DIRTY: dirty_mark[sidx] <= 1'b1;
                lbc_pkg::OP_CLEAN: dirty_mark[sidx] <= 1'b0;
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  `LBC_ASSERT(a_ready_idle, clk, rst, s_tready |-> state == lbc_pkg::S_IDLE)
  `LBC_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  `LBC_ASSERT(a_no_accept_full, clk, rst, m_tvalid |-> !s_tready)
endmodule

>>> hdl/lbc_scan_unit.sv
// ----------------------------------------------------------------------------
// lbc_scan_unit
// Shared compare unit: tests one slot per cycle for a tag hit or as a victim.
// ----------------------------------------------------------------------------
module lbc_scan_unit (
  input  logic [7:0]  dev,
  input  logic [31:0] blk,
  input  logic [7:0]  tag_dev,
  input  logic [31:0] tag_blk,
  input  logic [7:0]  count,
  input  logic        dirty,
  output logic        tag_match,
  output logic        free
);
  // One tag comparison and one free check.
  assign tag_match = (tag_dev == dev) && (tag_blk == blk);
  assign free      = (count == '0) && !dirty;
endmodule
